/* sv/ecef_to_geodetic_lat_lon_defines.svh */
// Assertion helpers for the geodetic converter.
`ifndef ECEF_TO_GEODETIC_LAT_LON_DEFINES_SVH
`define ECEF_TO_GEODETIC_LAT_LON_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define E2G_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("e2g check failed");

// Next-cycle implication, disabled in reset.
`define E2G_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("e2g check failed");

`endif

/* sv/e2g_pkg.sv */
package e2g_pkg;

    localparam int CORDIC_STEPS = 32;

    localparam logic signed [33:0] ANG_QUARTER = 34'sd1073741824;
    localparam logic signed [33:0] ANG_HALF    = 34'sd2147483648;
    localparam logic [39:0] INV_GAIN_Q32 = 40'd2608131496;
    localparam logic signed [63:0] INV_GAIN_Q30 = 64'sd652032874;
    localparam logic [63:0] E2_Q32     = 64'd28750686;
    localparam logic [63:0] E2A_MM_Q16 = 64'd2798092843608;

    typedef struct packed {
        logic signed [39:0] pos_x;
        logic signed [39:0] pos_y;
        logic signed [39:0] pos_z;
    } e2g_req_t;

    typedef struct packed {
        logic signed [32:0] longitude;
        logic signed [31:0] latitude;
        logic               hit_cap;
    } e2g_res_t;

    typedef struct packed {
        logic load;
        logic vec;
    } e2g_cor_ctl_t;

    typedef struct packed {
        logic load;
        logic sh30;
    } e2g_mul_ctl_t;

    // atan(2^-i) in binary angle units, 2^32 per turn
    function automatic logic signed [33:0] atan_tab(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            5'd30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // binary angle to degrees * 2^24, halves away from zero
    function automatic logic signed [33:0] to_out(input logic signed [33:0] a);
        logic [32:0] m;
        logic [38:0] p;
        logic [33:0] r;
        m = a[33] ? 33'(-a) : a[32:0];
        p = {6'd0, m} * 39'd45 + 39'd16;
        r = {1'b0, p[37:5]};
        return a[33] ? -$signed(r) : $signed(r);
    endfunction

endpackage

/* sv/e2g_cordic.sv */
module e2g_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  e2g_pkg::e2g_cor_ctl_t ctl,
    input  logic signed [63:0]    x0,
    input  logic signed [63:0]    y0,
    input  logic signed [33:0]    ang0,
    output logic signed [63:0]    x,
    output logic signed [63:0]    y,
    output logic signed [33:0]    ang,
    output logic                  done
);
    import e2g_pkg::*;

    logic signed [63:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [33:0] ang_reg, ang_next, t;
    logic [4:0] i_reg;
    logic run_reg, vec_reg, done_reg, plus;

    assign dx   = y_reg >>> i_reg;
    assign dy   = x_reg >>> i_reg;
    assign t    = atan_tab(i_reg);
    assign plus = vec_reg ? !y_reg[63] : ang_reg[33];

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        ang_next = ang_reg;
        if (ctl.load)
        begin
            x_next   = x0;
            y_next   = y0;
            ang_next = ang0;
            // quadrant pre-rotation for vectoring in the left half plane
            if (ctl.vec && x0[63])
            begin
                if (!y0[63])
                begin
                    x_next   = y0;
                    y_next   = -x0;
                    ang_next = ANG_QUARTER;
                end
                else
                begin
                    x_next   = -y0;
                    y_next   = x0;
                    ang_next = -ANG_QUARTER;
                end
            end
        end
        else if (run_reg)
        begin
            if (plus)
            begin
                x_next   = x_reg + dx;
                y_next   = y_reg - dy;
                ang_next = ang_reg + t;
            end
            else
            begin
                x_next   = x_reg - dx;
                y_next   = y_reg + dy;
                ang_next = ang_reg - t;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            run_reg  <= 1'b0;
            vec_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.load)
            begin
                i_reg   <= '0;
                run_reg <= 1'b1;
                vec_reg <= ctl.vec;
            end
            else if (run_reg)
            begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign ang  = ang_reg;
    assign done = done_reg;

endmodule

/* sv/e2g_mul.sv */
module e2g_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  e2g_pkg::e2g_mul_ctl_t ctl,
    input  logic [63:0]           a,
    input  logic [39:0]           b,
    output logic [63:0]           prod,
    output logic                  done
);
    import e2g_pkg::*;

    // byte-serial: acc = acc*256 + a*byte, MSB byte first
    logic [63:0]  a_reg;
    logic [39:0]  b_reg;
    logic [103:0] acc_reg;
    logic [71:0]  part;
    logic [2:0]   cnt_reg;
    logic run_reg, done_reg, sh30_reg;

    assign part = {8'd0, a_reg} * {64'd0, b_reg[39:32]};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg    <= a;
            b_reg    <= b;
            acc_reg  <= '0;
            sh30_reg <= ctl.sh30;
        end
        else if (run_reg)
        begin
            acc_reg <= {acc_reg[95:0], 8'd0} + {32'd0, part};
            b_reg   <= {b_reg[31:0], 8'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.load)
            begin
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign prod = sh30_reg ? acc_reg[93:30] : acc_reg[95:32];
    assign done = done_reg;

endmodule

/* sv/ecef_to_geodetic_lat_lon.sv */
// ECEF (mm) to geodetic longitude/latitude (degrees * 2^24) on the WGS84-style
// ellipsoid. A request is taken when start is high and busy is low; busy then
// stays high until the result has been shown. The result appears for exactly
// one cycle with done high and must be captured then: there is no stall.
// One shared CORDIC (load, 32 steps, done per atan2 or sin/cos) and one
// byte-serial multiplier (load, 5 byte steps, done per product) do all the work:
// longitude, the horizontal distance and the first latitude, then per refinement
// a sin/cos, six products and an atan2, up to MAX_ITERATIONS refinements, and
// last the S_OUT state that shows the result. Origin and polar axis answer in the
// cycle after acceptance, the equatorial plane after longitude and distance.
// hit_cap flags a latitude that was still moving at the cap.
module ecef_to_geodetic_lat_lon #(
    parameter int MAX_ITERATIONS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  e2g_pkg::e2g_req_t request,
    output logic              done,
    output e2g_pkg::e2g_res_t result
);
    import e2g_pkg::*;
    `include "ecef_to_geodetic_lat_lon_defines.svh"

    localparam int IT_W = $clog2(MAX_ITERATIONS + 1);

    // product steps of one refinement
    localparam logic [2:0] M_SQ    = 3'd0;   // s^2
    localparam logic [2:0] M_U     = 3'd1;   // e2 * s^2
    localparam logic [2:0] M_INNER = 3'd2;   // series inner term
    localparam logic [2:0] M_G     = 3'd3;   // series tail
    localparam logic [2:0] M_CORR  = 3'd4;   // e2 * N
    localparam logic [2:0] M_PROJ  = 3'd5;   // e2 * N * cos

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LON  = 8'b0000_0010,   // atan2(y, x)
        S_PQ   = 8'b0000_0100,   // p = |xy| / gain
        S_LAT0 = 8'b0000_1000,   // first guess atan2(z, p)
        S_ROT  = 8'b0001_0000,   // sin/cos of latitude
        S_MUL  = 8'b0010_0000,   // radius of curvature term
        S_VEC  = 8'b0100_0000,   // new latitude
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [39:0] px_reg, py_reg, pz_reg;
    logic signed [33:0] lon_reg, lon_next, lat_reg, lat_next;
    logic signed [63:0] pq_reg, pq_next, t_reg, t_next;
    logic [63:0] u_reg, u_next;
    logic [30:0] c_reg, c_next, sa_reg, sa_next;
    logic [2:0] idx_reg, idx_next;
    logic [IT_W-1:0] it_reg, it_next;
    logic pend_reg, pend_next, cap_reg, cap_next;

    // shared units
    e2g_cor_ctl_t cor_ctl;
    logic signed [63:0] cx0, cy0, cx, cy;
    logic signed [33:0] cang0, cang;
    logic cor_done;
    e2g_mul_ctl_t mul_ctl;
    logic [63:0] ma, mprod;
    logic [39:0] mb;
    logic mul_done;

    logic signed [63:0] zq, diff;
    logic signed [33:0] ang_lat;
    logic signed [33:0] lon_out, lat_out;
    logic [63:0] inner0;
    logic accept, xy_nz;

    assign accept = start && !busy;
    assign xy_nz  = (request.pos_x != '0) || (request.pos_y != '0);
    assign zq     = {{8{pz_reg[39]}}, pz_reg, 16'd0};
    assign diff   = pq_reg - $signed(mprod);
    assign inner0 = 64'd1610612736 + ((u_reg * 64'd5) >> 4);

    // latitude angle clamp to a quarter turn
    always_comb
    begin
        if (cang > ANG_QUARTER)
            ang_lat = ANG_QUARTER;
        else if (cang < -ANG_QUARTER)
            ang_lat = -ANG_QUARTER;
        else
            ang_lat = cang;
    end

    // unit operand selection
    always_comb
    begin
        cor_ctl.vec = (state_reg != S_ROT);
        cor_ctl.load = !pend_reg &&
                       (state_reg == S_LON || state_reg == S_LAT0 ||
                        state_reg == S_ROT || state_reg == S_VEC);
        cx0   = pq_reg;
        cy0   = zq;
        cang0 = '0;
        case (state_reg)
            S_LON:
            begin
                cx0 = {{8{px_reg[39]}}, px_reg, 16'd0};
                cy0 = {{8{py_reg[39]}}, py_reg, 16'd0};
            end
            S_ROT:
            begin
                cx0   = INV_GAIN_Q30;
                cy0   = '0;
                cang0 = lat_reg;
            end
            S_VEC:   cx0 = t_reg;
            default: cx0 = pq_reg;
        endcase

        mul_ctl.load = !pend_reg && (state_reg == S_PQ || state_reg == S_MUL);
        mul_ctl.sh30 = (state_reg == S_MUL) && (idx_reg == M_SQ || idx_reg == M_U);
        ma = t_reg;
        mb = INV_GAIN_Q32;
        if (state_reg == S_MUL)
        begin
            case (idx_reg)
                M_SQ:
                begin
                    ma = {33'd0, sa_reg};
                    mb = {9'd0, sa_reg};
                end
                M_U:
                begin
                    ma = E2_Q32;
                    mb = t_reg[39:0];
                end
                M_INNER:
                begin
                    ma = u_reg;
                    mb = inner0[39:0];
                end
                M_G:
                begin
                    ma = u_reg;
                    mb = t_reg[39:0];
                end
                M_CORR:
                begin
                    ma = E2A_MM_Q16;
                    mb = t_reg[39:0];
                end
                default:
                begin
                    ma = t_reg;
                    mb = {7'd0, c_reg, 2'd0};
                end
            endcase
        end
    end

    e2g_cordic u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (cor_ctl),
        .x0   (cx0),
        .y0   (cy0),
        .ang0 (cang0),
        .x    (cx),
        .y    (cy),
        .ang  (cang),
        .done (cor_done)
    );

    e2g_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (mul_ctl),
        .a    (ma),
        .b    (mb),
        .prod (mprod),
        .done (mul_done)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        lon_next   = lon_reg;
        lat_next   = lat_reg;
        pq_next    = pq_reg;
        t_next     = t_reg;
        u_next     = u_reg;
        c_next     = c_reg;
        sa_next    = sa_reg;
        idx_next   = idx_reg;
        it_next    = it_reg;
        cap_next   = cap_reg;
        pend_next  = pend_reg || cor_ctl.load || mul_ctl.load;
        if (cor_done || mul_done)
            pend_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    lon_next = '0;
                    pq_next  = '0;
                    cap_next = 1'b0;
                    lat_next = '0;
                    if (xy_nz)
                        state_next = S_LON;
                    else
                    begin
                        // origin or polar axis
                        if (request.pos_z != '0)
                            lat_next = request.pos_z[39] ? -ANG_QUARTER : ANG_QUARTER;
                        state_next = S_OUT;
                    end
                end
            end
            S_LON:
            begin
                if (cor_done)
                begin
                    if (cang > ANG_HALF)
                        lon_next = ANG_HALF;
                    else if (cang < -ANG_HALF)
                        lon_next = -ANG_HALF;
                    else
                        lon_next = cang;
                    t_next     = cx[63] ? '0 : cx;
                    state_next = S_PQ;
                end
            end
            S_PQ:
            begin
                if (mul_done)
                begin
                    pq_next    = $signed(mprod);
                    state_next = (pz_reg == '0) ? S_OUT : S_LAT0;
                end
            end
            S_LAT0:
            begin
                if (cor_done)
                begin
                    lat_next   = ang_lat;
                    cap_next   = 1'b1;
                    it_next    = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (cor_done)
                begin
                    if (cx > $signed({30'd0, ANG_QUARTER}))
                        c_next = 31'h4000_0000;
                    else if (cx[63])
                        c_next = '0;
                    else
                        c_next = cx[30:0];
                    if (cy > $signed({30'd0, ANG_QUARTER}) ||
                        cy < -$signed({30'd0, ANG_QUARTER}))
                        sa_next = 31'h4000_0000;
                    else if (cy[63])
                        sa_next = 31'(-cy);
                    else
                        sa_next = cy[30:0];
                    idx_next   = M_SQ;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    idx_next = idx_reg + 3'd1;
                    case (idx_reg)
                        M_SQ:    t_next = $signed(mprod);
                        M_U:     u_next = mprod;
                        M_INNER: t_next = $signed(mprod + 64'h8000_0000);
                        M_G:     t_next = $signed(mprod);
                        M_CORR:  t_next = $signed(mprod + E2A_MM_Q16);
                        default:
                        begin
                            // near the centre the term is floored at zero
                            t_next     = diff[63] ? '0 : diff;
                            state_next = S_VEC;
                        end
                    endcase
                end
            end
            S_VEC:
            begin
                if (cor_done)
                begin
                    if (ang_lat == lat_reg)
                    begin
                        cap_next   = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        lat_next = ang_lat;
                        it_next  = it_reg + IT_W'(1);
                        if (it_reg == IT_W'(MAX_ITERATIONS - 1))
                            state_next = S_OUT;
                        else
                            state_next = S_ROT;
                    end
                end
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= request.pos_x;
            py_reg <= request.pos_y;
            pz_reg <= request.pos_z;
        end
        lon_reg <= lon_next;
        lat_reg <= lat_next;
        pq_reg  <= pq_next;
        t_reg   <= t_next;
        u_reg   <= u_next;
        c_reg   <= c_next;
        sa_reg  <= sa_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            it_reg    <= '0;
            pend_reg  <= 1'b0;
            cap_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            it_reg    <= it_next;
            pend_reg  <= pend_next;
            cap_reg   <= cap_next;
        end
    end

    assign lon_out = to_out(lon_reg);
    assign lat_out = to_out(lat_reg);

    assign busy             = (state_reg != S_IDLE);
    assign done             = (state_reg == S_OUT);
    assign result.longitude = lon_out[32:0];
    assign result.latitude  = lat_out[31:0];
    assign result.hit_cap   = cap_reg;

    `E2G_ASSERT_NEXT(a_done_single, done, !done)
    `E2G_ASSERT_NEXT(a_done_frees, done, !busy)
    `E2G_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `E2G_ASSERT_NOW(a_lat_range, done,
        result.latitude <= 32'sd1509949440 && result.latitude >= -32'sd1509949440)
    `E2G_ASSERT_NOW(a_units_exclusive, cor_done, !mul_done)

endmodule

/* sim/ecef_to_geodetic_lat_lon_checker.sv */
`timescale 1ns / 1ps

// Scoreboard for the geodetic converter: predicts each accepted request and
// compares the strobed results in order.
module ecef_to_geodetic_lat_lon_checker #(
    parameter int MAX_ITERATIONS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  e2g_pkg::e2g_req_t  request,
    input  logic               done,
    input  e2g_pkg::e2g_res_t  result,
    output int                 errors,
    output int                 pending
);
    import e2g_pkg::*;

    localparam longint QUARTER = 64'sd1073741824;
    localparam longint HALF    = 64'sd2147483648;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam logic [63:0] GAIN_Q32 = 64'd2608131496;
    localparam logic [63:0] ECC2_Q32 = 64'd28750686;
    localparam logic [63:0] ECC2_A = 64'd2798092843608;

    e2g_res_t expected_fix_q[$];

    function automatic longint arc_step(input int i);
        longint t [32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        return t[i];
    endfunction

    // floor(a * c / 2^32), both unsigned
    function automatic logic [63:0] mul_frac(input logic [63:0] a, input logic [63:0] c);
        return (a >> 32) * c + (((a & 64'hFFFF_FFFF) * c) >> 32);
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // vectoring: angle of (x, y), gain-scaled length in mag
    function automatic longint arc_of(input longint x, input longint y, output longint mag);
        longint ang, t, dx, dy;
        ang = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;  y = -t; ang = QUARTER;
            end
            else begin
                x = -y; y = t;  ang = -QUARTER;
            end
        end
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; ang += arc_step(i);
            end
            else begin
                x -= dx; y += dy; ang -= arc_step(i);
            end
        end
        mag = x;
        return ang;
    endfunction

    function automatic longint to_degrees(input longint ang);
        longint m;
        m = (ang < 0) ? -ang : ang;
        m = (m * 45 + 16) >>> 5;
        return (ang < 0) ? -m : m;
    endfunction

    // one latitude refinement via prime-vertical radius
    function automatic longint refine_lat(input longint phi, input longint zq, input longint pq);
        longint c, s, dx, dy, d, unused;
        logic [63:0] s2, u, inner, g, corr;
        c = GAIN_Q30;
        s = 0;
        for (int i = 0; i < 32; i++) begin
            dx = s >>> i;
            dy = c >>> i;
            if (phi >= 0) begin
                c -= dx; s += dy; phi -= arc_step(i);
            end
            else begin
                c += dx; s -= dy; phi += arc_step(i);
            end
        end
        c = clamp(c, QUARTER);
        if (c < 0) c = 0;
        s = clamp(s, QUARTER);
        s2 = 64'(s * s) >> 30;
        u = (ECC2_Q32 * s2) >> 30;
        inner = (64'd3 << 29) + ((64'd5 * u) >> 4);
        inner = (64'd1 << 31) + ((u * inner) >> 32);
        g = (u * inner) >> 32;
        corr = ECC2_A + mul_frac(ECC2_A, g);
        corr = mul_frac(corr, 64'(c) << 2);
        d = pq - longint'(corr);
        if (d < 0) d = 0;
        return clamp(arc_of(d, zq, unused), QUARTER);
    endfunction

    function automatic e2g_res_t predict_fix(input e2g_req_t r);
        longint x, y, z, lon, lat, pq, mag, zq, nxt;
        e2g_res_t o;
        x = longint'(r.pos_x);
        y = longint'(r.pos_y);
        z = longint'(r.pos_z);
        lon = 0; lat = 0; pq = 0; mag = 0;
        zq = z * 65536;
        o.hit_cap = 1'b0;
        if (x != 0 || y != 0) begin
            lon = clamp(arc_of(x * 65536, y * 65536, mag), HALF);
            if (mag < 0) mag = 0;
            pq = longint'(mul_frac(64'(mag), GAIN_Q32));
        end
        if (z != 0) begin
            if (x == 0 && y == 0)
                lat = (z > 0) ? QUARTER : -QUARTER;
            else begin
                lat = clamp(arc_of(pq, zq, mag), QUARTER);
                o.hit_cap = 1'b1;
                for (int k = 0; k < MAX_ITERATIONS; k++) begin
                    nxt = refine_lat(lat, zq, pq);
                    if (nxt == lat) begin
                        o.hit_cap = 1'b0;
                        break;
                    end
                    lat = nxt;
                end
            end
        end
        o.longitude = 33'(to_degrees(lon));
        o.latitude  = 32'(to_degrees(lat));
        return o;
    endfunction

    assign pending = expected_fix_q.size();

    initial errors = 0;

    always @(posedge clk) begin
        e2g_res_t want;
        if (rst_n) begin
            if (start && !busy)
                expected_fix_q.push_back(predict_fix(request));
            if (done) begin
                if (expected_fix_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: lon %0d lat %0d cap %0d",
                                 result.longitude, result.latitude, result.hit_cap);
                end
                else begin
                    want = expected_fix_q.pop_front();
                    if (result.longitude !== want.longitude
                        || result.latitude !== want.latitude
                        || result.hit_cap !== want.hit_cap) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp lon %0d lat %0d cap %0d,",
                                      " got lon %0d lat %0d cap %0d"},
                                     want.longitude, want.latitude, want.hit_cap,
                                     result.longitude, result.latitude, result.hit_cap);
                    end
                end
            end
        end
    end

endmodule

/* sim/ecef_to_geodetic_lat_lon_test.sv */
`timescale 1ns / 1ps

module ecef_to_geodetic_lat_lon_test;
    import e2g_pkg::*;

    localparam int RANDOM_REQS = 1430;
    localparam int CALM_TAIL   = 200;    // last requests go with no gaps
    localparam int STALL_LIMIT = 5000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    e2g_req_t request;
    e2g_res_t result;
    int       errors;
    int       pending;
    int       idle_cycles;

    ecef_to_geodetic_lat_lon u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    ecef_to_geodetic_lat_lon_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: counts cycles with no accepted request and no result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** ecef_to_geodetic_lat_lon: FAILED **");
            $finish;
        end
    end

    // Present one request from a falling edge and hold it until accepted;
    // returns at the following falling edge with start still high.
    task automatic issue_fix(input longint x, input longint y, input longint z);
        start = 1'b1;
        request.pos_x = 40'(x);
        request.pos_y = 40'(y);
        request.pos_z = 40'(z);
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Optional gap, in random bursts.
    task automatic maybe_gap(input bit allow);
        if (allow && $urandom_range(3, 0) == 0)
        begin
            start = 1'b0;
            request = e2g_req_t'(120'({$urandom, $urandom, $urandom, $urandom}));
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
    endtask

    // Earth-scale coordinate, roughly +-8.6e9 mm.
    function automatic longint earth_coord();
        longint v;
        v = longint'($urandom) + (longint'($urandom_range(1, 0)) << 32);
        return $urandom_range(1, 0) ? -v : v;
    endfunction

    function automatic longint any_coord();
        return longint'($signed(40'({$urandom, $urandom})));
    endfunction

    function automatic longint pick_coord(input int mode);
        case (mode)
            0, 1, 2, 3, 4, 5: return earth_coord();
            6, 7:             return any_coord();
            8:                return $signed($urandom_range(2000, 0)) - 1000;
            default:          return 0;   // axis and plane cases
        endcase
    endfunction

    localparam longint MAXC = 64'sd549755813887;
    localparam longint MINC = -64'sd549755813888;

    initial
    begin
        int  mode;
        bit  gaps;
        longint x, y, z;

        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: origin, poles, equator, extremes, quadrants, near centre
        issue_fix(0, 0, 0);
        issue_fix(0, 0, 64'sd6356753400);
        issue_fix(0, 0, -64'sd6356753400);
        issue_fix(0, 0, MAXC);
        issue_fix(0, 0, MINC);
        issue_fix(64'sd6378137000, 0, 0);
        issue_fix(-64'sd6378137000, 1, 0);
        issue_fix(MAXC, MAXC, MAXC);
        issue_fix(MINC, MINC, MINC);
        issue_fix(MAXC, MINC, 1);
        issue_fix(MINC, MAXC, -1);
        issue_fix(MINC, 0, MAXC);
        issue_fix(-1, 0, 5);
        issue_fix(-1, -1, -1);
        issue_fix(1, 1, 1000000);             // near centre, correction clips
        issue_fix(4000, 0, -3000);
        issue_fix(64'sd4510731000, 64'sd4510731000, 0);
        issue_fix(-64'sd2694892460, -64'sd4293083990, 64'sd3857878920);
        issue_fix(64'sd3194419000, -64'sd3194419000, -64'sd4487348000);
        issue_fix(-64'sd4000000000, 64'sd3000000000, 64'sd4000000000);
        issue_fix(1, 0, MAXC);                // off-axis, far out
        issue_fix(MAXC, 0, -MAXC);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            gaps = (n < RANDOM_REQS - CALM_TAIL);
            maybe_gap(gaps);
            // sender holds off until everything is back once mid-run
            if (n == RANDOM_REQS / 2)
            begin
                start = 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            mode = $urandom_range(9, 0);
            x = pick_coord(mode);
            y = pick_coord(($urandom_range(4, 0) == 0) ? 9 : mode);
            z = pick_coord(($urandom_range(6, 0) == 0) ? 9 : mode);
            issue_fix(x, y, z);
        end
        start = 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("** ecef_to_geodetic_lat_lon: PASSED **");
        else
            $display("** ecef_to_geodetic_lat_lon: FAILED **");
        $finish;
    end

endmodule
